@@ rtl/input_event_queue_with_button_repeat_core_macros.svh @@
// Assertion macros shared by the checker.
`ifndef INPUT_EVENT_QUEUE_WITH_BUTTON_REPEAT_CORE_MACROS_SVH
`define INPUT_EVENT_QUEUE_WITH_BUTTON_REPEAT_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IEQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ieq assertion failed");

// next-cycle implication, disabled in reset
`define IEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ieq assertion failed");

`endif

@@ rtl/ieq_pkg.sv @@
package ieq_pkg;

  localparam int MODE_W    = 3;
  localparam int KEY_W     = 9;
  localparam int POS_W     = 16;
  localparam int CHAR_W    = 16;
  localparam int MOD_W     = 3;
  localparam int MASK_W    = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W    = 32;
  localparam int LEVEL_W   = 9;
  localparam int TYPE_W    = 4;
  localparam int KEY_SPACE = 1 << KEY_W;

  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd250;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd50;
  localparam logic [CFG_W-1:0] DBL_WINDOW_RST      = 16'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_DELAY    = 2'd0,
    CFG_REPEAT_INTERVAL = 2'd1,
    CFG_DBL_WINDOW      = 2'd2
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK        = 3'd0,
    MODE_BTN_PRESS   = 3'd1,
    MODE_BTN_RELEASE = 3'd2,
    MODE_KEY_PRESS   = 3'd3,
    MODE_KEY_RELEASE = 3'd4,
    MODE_DEQ         = 3'd5,
    MODE_MASKED_DEQ  = 3'd6
  } mode_t;

  typedef enum logic [TYPE_W-1:0] {
    EV_LDOWN = 4'd0,
    EV_LUP   = 4'd1,
    EV_LDBL  = 4'd2,
    EV_LREP  = 4'd3,
    EV_RDOWN = 4'd4,
    EV_RUP   = 4'd5,
    EV_RREP  = 4'd6,
    EV_KDOWN = 4'd7,
    EV_KREP  = 4'd8,
    EV_KUP   = 4'd9
  } ev_type_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [MOD_W-1:0]  mods;
    logic [KEY_W-1:0]  key;
    ev_type_t          etype;
  } ev_entry_t;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     tick;
    logic     btn_press;
    logic     btn_release;
    logic     last_click;
    logic     push;
    ev_type_t push_type;
    logic     push_key;
    logic     map_rd;
    logic     map_wr;
    logic     map_val;
    logic     svc_left;
    logic     svc_right;
    logic     q_rd;
    logic     pop;
    logic     respond;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  is_left;
    logic  dbl_hit;
    logic  key_valid;
    logic  key_set;
    logic  q_empty;
    logic  head_ok;
    logic  clr_last;
  } dp_sts_t;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_EXEC  = 11'b000_0000_0100,
    S_DBL   = 11'b000_0000_1000,
    S_KEY   = 11'b000_0001_0000,
    S_CHK   = 11'b000_0010_0000,
    S_SVCL  = 11'b000_0100_0000,
    S_SVCR  = 11'b000_1000_0000,
    S_QRD   = 11'b001_0000_0000,
    S_POP   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

endpackage

@@ rtl/ieq_datapath.sv @@
module ieq_datapath import ieq_pkg::*; #(
  parameter int QUEUE_DEPTH = 256,
  parameter int KEYS        = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic                 in_button,
  input  logic [POS_W-1:0]     in_pointer_x,
  input  logic [POS_W-1:0]     in_pointer_y,
  input  logic [KEY_W-1:0]     in_key_code,
  input  logic [MOD_W-1:0]     in_modifiers,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [MASK_W-1:0]    in_event_mask,
  output logic                 out_strobe,
  output logic                 out_valid_res,
  output logic [TYPE_W-1:0]    out_event_type,
  output logic [KEY_W-1:0]     out_event_key,
  output logic [MOD_W-1:0]     out_event_modifiers,
  output logic [CHAR_W-1:0]    out_event_char,
  output logic [POS_W-1:0]     out_mouse_x,
  output logic [POS_W-1:0]     out_mouse_y,
  output logic                 out_left_held,
  output logic                 out_right_held,
  output logic [LEVEL_W-1:0]   out_queue_level
);

  localparam int QAW        = $clog2(QUEUE_DEPTH);
  localparam int QCW        = $clog2(QUEUE_DEPTH + 1);
  localparam int KMAP_DEPTH = (KEYS < KEY_SPACE) ? KEYS : KEY_SPACE;
  localparam int KAW        = $clog2(KMAP_DEPTH);

  logic [CFG_W-1:0]  delay_r, interval_r, window_r;
  logic [TIME_W-1:0] now_r, ldl_r, rdl_r, lastclk_r;
  logic              ldown_r, rdown_r;
  logic [POS_W-1:0]  posx_r, posy_r;
  logic [QAW-1:0]    head_r, tail_r;
  logic [QCW-1:0]    fill_r;
  logic [KAW-1:0]    clr_cnt_r;
  logic              res_valid_r;

  logic [MODE_W-1:0] mode_r;
  logic              btn_r;
  logic [POS_W-1:0]  px_r, py_r;
  logic [KEY_W-1:0]  key_r;
  logic [MOD_W-1:0]  mods_r;
  logic [CHAR_W-1:0] ch_r;
  logic [MASK_W-1:0] mask_r;
  ev_entry_t         q_rd_r, res_entry_r, out_entry_r;
  logic              kmap_rd_r;

  logic              out_strobe_r, out_valid_r, out_left_r, out_right_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  logic [LEVEL_W-1:0] out_level_r;

  ev_entry_t         evq_mem [QUEUE_DEPTH];
  logic              kmap_mem [KMAP_DEPTH];

  logic              svc_l_due, svc_r_due, push_req, q_full, do_push;
  ev_type_t          push_type;
  ev_entry_t         push_ent;
  logic [KAW-1:0]    kaddr;
  logic [QAW-1:0]    tail_nxt, head_nxt;

  assign q_full    = (fill_r == QCW'(QUEUE_DEPTH));
  assign svc_l_due = cmd.svc_left && ldown_r && (ldl_r != '0) && (ldl_r <= now_r);
  assign svc_r_due = cmd.svc_right && rdown_r && (rdl_r != '0) && (rdl_r <= now_r);
  assign push_req  = cmd.push || svc_l_due || svc_r_due;
  assign do_push   = push_req && !q_full;
  assign kaddr     = key_r[KAW-1:0];
  assign tail_nxt  = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign head_nxt  = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    if (svc_l_due) begin
      push_type = EV_LREP;
    end else if (svc_r_due) begin
      push_type = EV_RREP;
    end else begin
      push_type = cmd.push_type;
    end
    push_ent.etype = push_type;
    push_ent.key   = cmd.push_key ? key_r : '0;
    push_ent.mods  = cmd.push_key ? mods_r : '0;
    push_ent.ch    = cmd.push_key ? ch_r : '0;
  end

  always_comb begin
    sts.mode      = mode_t'(mode_r);
    sts.is_left   = !btn_r;
    sts.dbl_hit   = ((now_r - lastclk_r) < TIME_W'(window_r));
    sts.key_valid = (32'(key_r) < 32'(KEYS));
    sts.key_set   = kmap_rd_r;
    sts.q_empty   = (fill_r == '0);
    sts.head_ok   = (q_rd_r.etype <= EV_KUP) && mask_r[q_rd_r.etype];
    sts.clr_last  = (clr_cnt_r == KAW'(KMAP_DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r      <= REPEAT_DELAY_RST;
      interval_r   <= REPEAT_INTERVAL_RST;
      window_r     <= DBL_WINDOW_RST;
      now_r        <= '0;
      ldl_r        <= '0;
      rdl_r        <= '0;
      lastclk_r    <= '0;
      ldown_r      <= 1'b0;
      rdown_r      <= 1'b0;
      posx_r       <= '0;
      posy_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      clr_cnt_r    <= '0;
      res_valid_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REPEAT_DELAY:    delay_r    <= cfg_data;
          CFG_REPEAT_INTERVAL: interval_r <= cfg_data;
          CFG_DBL_WINDOW:      window_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.load) begin
        res_valid_r <= 1'b0;
      end
      if (cmd.tick) begin
        now_r <= now_r + 1'b1;
      end
      if (cmd.btn_press) begin
        posx_r <= px_r;
        posy_r <= py_r;
        if (!btn_r) begin
          ldl_r   <= now_r + TIME_W'(delay_r);
          ldown_r <= 1'b1;
        end else begin
          rdl_r   <= now_r + TIME_W'(delay_r);
          rdown_r <= 1'b1;
        end
      end
      if (cmd.btn_release) begin
        posx_r <= px_r;
        posy_r <= py_r;
        if (!btn_r) begin
          ldl_r   <= '0;
          ldown_r <= 1'b0;
        end else begin
          rdl_r   <= '0;
          rdown_r <= 1'b0;
        end
      end
      if (cmd.last_click) begin
        lastclk_r <= now_r;
      end
      if (cmd.svc_left) begin
        if (!ldown_r) begin
          ldl_r <= '0;
        end else if (svc_l_due) begin
          ldl_r <= now_r + TIME_W'(interval_r);
        end
      end
      if (cmd.svc_right) begin
        if (!rdown_r) begin
          rdl_r <= '0;
        end else if (svc_r_due) begin
          rdl_r <= now_r + TIME_W'(interval_r);
        end
      end
      if (do_push) begin
        tail_r <= tail_nxt;
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r      <= head_nxt;
        fill_r      <= fill_r - 1'b1;
        res_valid_r <= 1'b1;
      end
      out_strobe_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r      <= in_mode;
      btn_r       <= in_button;
      px_r        <= in_pointer_x;
      py_r        <= in_pointer_y;
      key_r       <= in_key_code;
      mods_r      <= in_modifiers;
      ch_r        <= in_char_code;
      mask_r      <= in_event_mask;
      res_entry_r <= '0;
    end
    if (cmd.pop) begin
      res_entry_r <= q_rd_r;
    end
    if (cmd.respond) begin
      out_valid_r <= res_valid_r;
      out_entry_r <= res_entry_r;
      out_x_r     <= posx_r;
      out_y_r     <= posy_r;
      out_left_r  <= ldown_r;
      out_right_r <= rdown_r;
      out_level_r <= LEVEL_W'(fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      evq_mem[tail_r] <= push_ent;
    end
    if (cmd.q_rd) begin
      q_rd_r <= evq_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      kmap_mem[clr_cnt_r] <= 1'b0;
    end else if (cmd.map_wr) begin
      kmap_mem[kaddr] <= cmd.map_val;
    end
    if (cmd.map_rd) begin
      kmap_rd_r <= kmap_mem[kaddr];
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_valid_res       = out_valid_r;
  assign out_event_type      = out_entry_r.etype;
  assign out_event_key       = out_entry_r.key;
  assign out_event_modifiers = out_entry_r.mods;
  assign out_event_char      = out_entry_r.ch;
  assign out_mouse_x         = out_x_r;
  assign out_mouse_y         = out_y_r;
  assign out_left_held       = out_left_r;
  assign out_right_held      = out_right_r;
  assign out_queue_level     = out_level_r;

endmodule

@@ rtl/ieq_ctrl.sv @@
module ieq_ctrl import ieq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (sts.mode)
          MODE_TICK: begin
            cmd.tick = 1'b1;
          end
          MODE_BTN_PRESS: begin
            cmd.btn_press = 1'b1;
            cmd.push      = 1'b1;
            cmd.push_type = sts.is_left ? EV_LDOWN : EV_RDOWN;
          end
          MODE_BTN_RELEASE: begin
            cmd.btn_release = 1'b1;
            cmd.push        = 1'b1;
            cmd.push_type   = sts.is_left ? EV_LUP : EV_RUP;
            if (sts.is_left && sts.dbl_hit) begin
              state_nxt = S_DBL;
            end else begin
              cmd.last_click = sts.is_left;
            end
          end
          MODE_KEY_PRESS, MODE_KEY_RELEASE: begin
            cmd.map_rd = 1'b1;
            state_nxt  = S_KEY;
          end
          MODE_DEQ: begin
            state_nxt = S_SVCL;
          end
          MODE_MASKED_DEQ: begin
            if (!sts.q_empty) begin
              cmd.q_rd  = 1'b1;
              state_nxt = S_CHK;
            end
          end
          default: ;
        endcase
      end
      S_DBL: begin
        cmd.push      = 1'b1;
        cmd.push_type = EV_LDBL;
        state_nxt     = S_DONE;
      end
      S_KEY: begin
        state_nxt = S_DONE;
        if (sts.key_valid) begin
          if (sts.mode == MODE_KEY_PRESS) begin
            cmd.map_wr    = 1'b1;
            cmd.map_val   = 1'b1;
            cmd.push      = 1'b1;
            cmd.push_key  = 1'b1;
            cmd.push_type = sts.key_set ? EV_KREP : EV_KDOWN;
          end else if (sts.key_set) begin
            cmd.map_wr    = 1'b1;
            cmd.map_val   = 1'b0;
            cmd.push      = 1'b1;
            cmd.push_key  = 1'b1;
            cmd.push_type = EV_KUP;
          end
        end
      end
      S_CHK: begin
        state_nxt = sts.head_ok ? S_SVCL : S_DONE;
      end
      S_SVCL: begin
        cmd.svc_left = 1'b1;
        state_nxt    = S_SVCR;
      end
      S_SVCR: begin
        cmd.svc_right = 1'b1;
        // masked path already holds the head entry
        state_nxt     = (sts.mode == MODE_DEQ) ? S_QRD : S_POP;
      end
      S_QRD: begin
        if (sts.q_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.q_rd  = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/input_event_queue_with_button_repeat_core.sv @@
// Input event queue with mouse button repeat and double click.
// Input channel: an item (in_* fields) is taken when start is high and busy is low.
// Result channel: one result per item, shown on out_* for one cycle with out_strobe.
//   The receiver cannot stall; a result must be captured in its strobe cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high; write only while busy is low.
// Steps: each accepted item passes through S_EXEC and then S_DONE, which issues
//   the result; left release with double click adds S_DBL, key items add S_KEY,
//   dequeue adds S_SVCL, S_SVCR, S_QRD and, unless the queue is empty, S_POP, and
//   masked dequeue of a non-empty queue adds S_CHK and, if the head entry passes
//   the mask, S_SVCL, S_SVCR and S_POP. busy drops in the strobe cycle, so the next
//   item can be taken there; no new item is taken while one is in work. Each memory
//   gets at most one access per controller state, as single-port memories need.
// Reset (rst_n low, synchronous) clears all control state, restores register
//   defaults and then clears the key map one entry per cycle: busy stays high
//   until all min(KEYS, 512) entries are clear. The event store is not cleared.
module input_event_queue_with_button_repeat_core import ieq_pkg::*; #(
  parameter int QUEUE_DEPTH = 256,
  parameter int KEYS        = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic                 in_button,
  input  logic [POS_W-1:0]     in_pointer_x,
  input  logic [POS_W-1:0]     in_pointer_y,
  input  logic [KEY_W-1:0]     in_key_code,
  input  logic [MOD_W-1:0]     in_modifiers,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [MASK_W-1:0]    in_event_mask,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_strobe,
  output logic                 out_valid_res,
  output logic [TYPE_W-1:0]    out_event_type,
  output logic [KEY_W-1:0]     out_event_key,
  output logic [MOD_W-1:0]     out_event_modifiers,
  output logic [CHAR_W-1:0]    out_event_char,
  output logic [POS_W-1:0]     out_mouse_x,
  output logic [POS_W-1:0]     out_mouse_y,
  output logic                 out_left_held,
  output logic                 out_right_held,
  output logic [LEVEL_W-1:0]   out_queue_level
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ieq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ieq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEYS        (KEYS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_mode             (in_mode),
    .in_button           (in_button),
    .in_pointer_x        (in_pointer_x),
    .in_pointer_y        (in_pointer_y),
    .in_key_code         (in_key_code),
    .in_modifiers        (in_modifiers),
    .in_char_code        (in_char_code),
    .in_event_mask       (in_event_mask),
    .out_strobe          (out_strobe),
    .out_valid_res       (out_valid_res),
    .out_event_type      (out_event_type),
    .out_event_key       (out_event_key),
    .out_event_modifiers (out_event_modifiers),
    .out_event_char      (out_event_char),
    .out_mouse_x         (out_mouse_x),
    .out_mouse_y         (out_mouse_y),
    .out_left_held       (out_left_held),
    .out_right_held      (out_right_held),
    .out_queue_level     (out_queue_level)
  );

endmodule

@@ rtl/ieq_checker.sv @@
`include "input_event_queue_with_button_repeat_core_macros.svh"

module ieq_checker import ieq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic              out_valid_res,
  input logic [TYPE_W-1:0] out_event_type,
  input logic [KEY_W-1:0]  out_event_key,
  input logic [MOD_W-1:0]  out_event_modifiers,
  input logic [CHAR_W-1:0] out_event_char
);

  logic ev_zero;

  assign ev_zero = (out_event_type == '0) && (out_event_key == '0) &&
                   (out_event_modifiers == '0) && (out_event_char == '0);

  `IEQ_ASSERT_IMP(a_strobe_after_work, out_strobe, $past(busy))
  `IEQ_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `IEQ_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !out_strobe)
  `IEQ_ASSERT_IMP(a_no_pop_zero, out_strobe && !out_valid_res, ev_zero)

endmodule

bind input_event_queue_with_button_repeat_core ieq_checker u_ieq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_valid_res       (out_valid_res),
  .out_event_type      (out_event_type),
  .out_event_key       (out_event_key),
  .out_event_modifiers (out_event_modifiers),
  .out_event_char      (out_event_char)
);
